[rtl/timed_event_table_top_macros.svh]
// Assertion macros shared by the timed event table RTL.
`ifndef TIMED_EVENT_TABLE_TOP_MACROS_SVH
`define TIMED_EVENT_TABLE_TOP_MACROS_SVH

// Property checked on every rising clock edge while out of reset.
`define TET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen while out of reset.
`define TET_NEVER(lbl, cond, msg) \
  `TET_ASSERT(lbl, !(cond), msg)

`endif

[rtl/tet_pkg.sv]
// Types, codes and helper functions for the timed event table.
`timescale 1ns / 1ps

package tet_pkg;

  // Default number of event slots, one cell per slot.
  localparam int EVENT_SLOTS_DEF = 32;

  // Field widths of one word.
  localparam int LIGHT_IN_W = 6;
  localparam int LIGHT_W    = 5;
  localparam int DAY_W      = 4;
  localparam int MINUTE_W   = 11;
  localparam int TODAY_W    = 3;
  localparam int STATUS_W   = 2;

  // Request codes.
  typedef enum logic [1:0] {
    MODE_ON     = 2'd0,
    MODE_OFF    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  // Status codes reported in status and done words.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // Day codes beyond the plain days of the week.
  localparam logic [DAY_W-1:0] DAY_EVERY   = 4'd7;
  localparam logic [DAY_W-1:0] DAY_WEEKDAY = 4'd8;
  localparam logic [DAY_W-1:0] DAY_WEEKEND = 4'd9;

  // Plain day numbers used by the weekend test.
  localparam logic [TODAY_W-1:0] SUNDAY   = 3'd0;
  localparam logic [TODAY_W-1:0] SATURDAY = 3'd6;

  // Request broadcast to every cell while a word is being processed.
  typedef struct packed {
    mode_t                 mode;
    logic [LIGHT_IN_W-1:0] light;
    logic [DAY_W-1:0]      day;
    logic [MINUTE_W-1:0]   minute;
    logic [TODAY_W-1:0]    today;
    logic [MINUTE_W-1:0]   now;
  } req_t;

  // True when a stored day code fires on the given day of the week.
  function automatic logic day_matches(logic [DAY_W-1:0] code, logic [TODAY_W-1:0] today);
    logic m;
    m = (code == DAY_EVERY) || (code == {1'b0, today});
    if ((code == DAY_WEEKEND) && ((today == SUNDAY) || (today == SATURDAY))) begin
      m = 1'b1;
    end
    if ((code == DAY_WEEKDAY) && (today inside {[3'd1:3'd5]})) begin
      m = 1'b1;
    end
    return m;
  endfunction

endpackage

[rtl/tet_cell.sv]
// One event slot of the table, acting when the scan token passes through it.
`timescale 1ns / 1ps

module tet_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         tok_i,
  input  logic                         claim_i,
  input  tet_pkg::req_t                req,
  output logic                         tok_o,
  output logic                         claim_o,
  output logic                         hit_o,
  output logic [tet_pkg::LIGHT_W-1:0]  hit_light_o,
  output logic                         hit_on_o
);
  import tet_pkg::*;

  logic                 tok_r;
  logic                 claim_r;
  logic                 used_r;
  logic [LIGHT_W-1:0]   light_r;
  logic [DAY_W-1:0]     day_r;
  logic [MINUTE_W-1:0]  minute_r;
  logic                 is_on_r;
  logic                 sched;
  logic                 take;
  logic                 kill;

  // Decode what this slot does while it holds the token.
  always_comb begin
    sched = (req.mode == MODE_ON) || (req.mode == MODE_OFF);
    take  = tok_r && sched && !claim_r && !used_r;
    kill  = tok_r && (req.mode == MODE_REMOVE) && used_r &&
            (req.light == {1'b0, light_r}) && (req.day == day_r) &&
            (req.minute == minute_r);
    hit_o = tok_r && (req.mode == MODE_TICK) && used_r &&
            day_matches(day_r, req.today) && (minute_r == req.now);
  end

  assign tok_o       = tok_r;
  assign claim_o     = claim_r || take;
  assign hit_light_o = light_r;
  assign hit_on_o    = is_on_r;

  // Token and claim flag move on to the next cell on each step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      claim_r <= 1'b0;
      used_r  <= 1'b0;
    end else if (step) begin
      tok_r   <= tok_i;
      claim_r <= claim_i;
      if (take) begin
        used_r <= 1'b1;
      end else if (kill) begin
        used_r <= 1'b0;
      end
    end
  end

  // Slot contents are written only when the slot is claimed.
  always_ff @(posedge clk) begin
    if (step && take) begin
      light_r  <= req.light[LIGHT_W-1:0];
      day_r    <= req.day;
      minute_r <= req.minute;
      is_on_r  <= (req.mode == MODE_ON);
    end
  end

endmodule

[rtl/timed_event_table_top.sv]
// Top level of the timed event table: request control, cell chain and output register.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake              | Carries
//  in_     | slave     | in_tvalid / in_tready  | one request word
//  out_    | master    | out_tvalid / out_tready| status, command and done words
//
//  A request token walks the chain one cell per cycle unless a held tick command stalls it;
//  a schedule, remove or tick word is finished before the next word can be taken.
//  A schedule word with a light above 31 skips the chain and goes straight to its done word.
//  Each light command of a tick holds the chain while the output register is still full.
//  Reset is synchronous and clears all slot used marks at once; no clearing pass.
//  A finished word may wait in the output register while the next request is accepted.

module timed_event_table_top #(
  parameter int EVENT_SLOTS = tet_pkg::EVENT_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, lowest bit up: light_id[5:0], day_code[9:6], minute_of_day[20:10],
  // today[23:21], now_minute[34:24], zero fill[39:35]
  input  logic [39:0] in_tdata,
  // in_tuser: mode[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata, lowest bit up: status[1:0], cmd_light[6:2], turn_on[7]
  output logic [7:0]  out_tdata,
  // out_tuser: kind[0]
  output logic        out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready
);
  import tet_pkg::*;
  `include "timed_event_table_top_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                state_r;
  req_t                  req_r;
  req_t                  req_in;
  logic [STATUS_W-1:0]   fin_status_r;
  logic                  out_valid_r;
  logic [7:0]            out_data_r;
  logic                  out_kind_r;
  logic                  out_last_r;

  logic                  accept;
  logic                  in_sched;
  logic                  bad_id;
  logic                  start;
  logic                  can_load;
  logic                  out_load;
  logic                  step;
  logic                  hit_any;
  logic [LIGHT_W-1:0]    hit_light;
  logic                  hit_on;

  logic [EVENT_SLOTS-1:0] tok;
  logic [EVENT_SLOTS-1:0] claim;
  logic [EVENT_SLOTS-1:0] hit;
  logic [LIGHT_W-1:0]     cell_light [EVENT_SLOTS];
  logic [EVENT_SLOTS-1:0] cell_on;

  // Unpack the request word.
  always_comb begin
    req_in.mode   = mode_t'(in_tuser);
    req_in.light  = in_tdata[5:0];
    req_in.day    = in_tdata[9:6];
    req_in.minute = in_tdata[20:10];
    req_in.today  = in_tdata[23:21];
    req_in.now    = in_tdata[34:24];
  end

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_sched  = (req_in.mode == MODE_ON) || (req_in.mode == MODE_OFF);
  assign bad_id    = in_sched && req_in.light[LIGHT_IN_W-1];
  assign start     = accept && !bad_id;
  assign can_load  = !out_valid_r || out_tready;
  assign step      = !hit_any || can_load;

  // The output register takes either a light command or the final status word.
  assign out_load  = ((state_r == S_SCAN) && hit_any && can_load) ||
                     ((state_r == S_DONE) && can_load);

  // Row of slot cells; the token and claim flag ripple one cell per step.
  for (genvar k = 0; k < EVENT_SLOTS; k++) begin : g_cell
    logic tok_in;
    logic claim_in;
    if (k == 0) begin : g_head
      assign tok_in   = start;
      assign claim_in = 1'b0;
    end else begin : g_body
      assign tok_in   = tok[k-1];
      assign claim_in = claim[k-1];
    end
    tet_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .step        (step),
      .tok_i       (tok_in),
      .claim_i     (claim_in),
      .req         (req_r),
      .tok_o       (tok[k]),
      .claim_o     (claim[k]),
      .hit_o       (hit[k]),
      .hit_light_o (cell_light[k]),
      .hit_on_o    (cell_on[k])
    );
  end

  // At most one cell holds the token, so the hit select is a plain OR.
  always_comb begin
    hit_light = '0;
    hit_on    = 1'b0;
    for (int k = 0; k < EVENT_SLOTS; k++) begin
      if (hit[k]) begin
        hit_light = hit_light | cell_light[k];
        hit_on    = hit_on | cell_on[k];
      end
    end
    hit_any = |hit;
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_in;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      fin_status_r <= ST_OK;
      out_data_r   <= '0;
      out_kind_r   <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            fin_status_r <= bad_id ? ST_BAD_ID : ST_OK;
            state_r      <= bad_id ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_any && can_load) begin
            out_data_r  <= {hit_on, hit_light, ST_OK};
            out_kind_r  <= 1'b1;
            out_last_r  <= 1'b0;
          end
          if (step && tok[EVENT_SLOTS-1]) begin
            if (((req_r.mode == MODE_ON) || (req_r.mode == MODE_OFF)) &&
                !claim[EVENT_SLOTS-1]) begin
              fin_status_r <= ST_FULL;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (can_load) begin
            out_data_r  <= {1'b0, {LIGHT_W{1'b0}}, fin_status_r};
            out_kind_r  <= 1'b0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Checks on the token chain and the sequencer.
  `TET_ASSERT(a_tok_onehot, $onehot0(tok), "more than one cell holds the token")
  `TET_ASSERT(a_idle_no_tok, (state_r != S_SCAN) |-> (tok == '0), "token outside a scan")
  `TET_NEVER(a_hit_outside_scan, hit_any && (state_r != S_SCAN), "command hit outside a scan")
  `TET_ASSERT(a_start_enters, start |=> (tok[0] && (state_r == S_SCAN)), "token not injected")

endmodule

[sim/tet_checker.sv]
// Checker for the timed event table: keeps its own slot table, predicts result words and compares them.
`timescale 1ns / 1ps

module tet_checker #(
  parameter int SLOTS = tet_pkg::EVENT_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  output int          words_awaited,
  output int          mismatches
);
  import tet_pkg::*;

  // One result word as the block should present it.
  typedef struct packed {
    logic                kind;
    logic [STATUS_W-1:0] status;
    logic [LIGHT_W-1:0]  light;
    logic                turn_on;
    logic                last;
  } table_word_t;

  // Shadow copy of the event table.
  logic                slot_used   [SLOTS];
  logic [LIGHT_W-1:0]  slot_light  [SLOTS];
  logic [DAY_W-1:0]    slot_day    [SLOTS];
  logic [MINUTE_W-1:0] slot_minute [SLOTS];
  logic                slot_is_on  [SLOTS];

  table_word_t awaited_words[$];

  initial mismatches = 0;

  // Compare each accepted result word, then fold each accepted request into the table.
  always @(posedge clk) begin : track
    table_word_t           got;
    table_word_t           want;
    logic [STATUS_W-1:0]   sched_status;
    logic                  fires;
    logic [LIGHT_IN_W-1:0] req_light;
    logic [DAY_W-1:0]      req_day;
    logic [MINUTE_W-1:0]   req_minute;
    logic [TODAY_W-1:0]    req_today;
    logic [MINUTE_W-1:0]   req_now;
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_used[s] = 1'b0;
      end
      awaited_words.delete();
      words_awaited <= 0;
    end else begin
      // Result side: the oldest awaited word must match field by field.
      if (out_tvalid && out_tready) begin
        got = '{kind: out_tuser, status: out_tdata[1:0], light: out_tdata[6:2],
                turn_on: out_tdata[7], last: out_tlast};
        if (awaited_words.size() == 0) begin
          $error("word with nothing awaited: kind %0d status %0d cmd_light %0d turn_on %0d",
                 got.kind, got.status, got.light, got.turn_on);
          mismatches++;
        end else begin
          want = awaited_words.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.light !== want.light) begin
            $error("cmd_light: expected %0d, got %0d", want.light, got.light);
            mismatches++;
          end
          if (got.turn_on !== want.turn_on) begin
            $error("turn_on: expected %0d, got %0d", want.turn_on, got.turn_on);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatches++;
          end
        end
      end

      // Request side: update the table and queue the words this request causes.
      if (in_tvalid && in_tready) begin
        req_light  = in_tdata[5:0];
        req_day    = in_tdata[9:6];
        req_minute = in_tdata[20:10];
        req_today  = in_tdata[23:21];
        req_now    = in_tdata[34:24];
        case (mode_t'(in_tuser))
          MODE_ON, MODE_OFF: begin
            // The first free slot takes the event; lights above 31 are refused.
            sched_status = ST_FULL;
            if (req_light > LIGHT_IN_W'(31)) begin
              sched_status = ST_BAD_ID;
            end else begin
              for (int s = 0; s < SLOTS; s++) begin
                if (sched_status == ST_FULL && !slot_used[s]) begin
                  slot_used[s]   = 1'b1;
                  slot_light[s]  = req_light[LIGHT_W-1:0];
                  slot_day[s]    = req_day;
                  slot_minute[s] = req_minute;
                  slot_is_on[s]  = (mode_t'(in_tuser) == MODE_ON);
                  sched_status   = ST_OK;
                end
              end
            end
            awaited_words.push_back('{kind: 1'b0, status: sched_status, light: '0,
                                      turn_on: 1'b0, last: 1'b1});
          end
          MODE_REMOVE: begin
            // Every matching slot is freed; a light above 31 can never match.
            for (int s = 0; s < SLOTS; s++) begin
              if (slot_used[s] && {1'b0, slot_light[s]} == req_light &&
                  slot_day[s] == req_day && slot_minute[s] == req_minute) begin
                slot_used[s] = 1'b0;
              end
            end
            awaited_words.push_back('{kind: 1'b0, status: ST_OK, light: '0,
                                      turn_on: 1'b0, last: 1'b1});
          end
          default: begin
            // Minute tick: one command per firing slot in slot order, then the done word.
            for (int s = 0; s < SLOTS; s++) begin
              case (slot_day[s])
                DAY_EVERY:   fires = 1'b1;
                DAY_WEEKDAY: fires = (req_today >= 3'd1) && (req_today <= 3'd5);
                DAY_WEEKEND: fires = (req_today == SUNDAY) || (req_today == SATURDAY);
                default:     fires = (slot_day[s] == {1'b0, req_today});
              endcase
              if (slot_used[s] && fires && slot_minute[s] == req_now) begin
                awaited_words.push_back('{kind: 1'b1, status: ST_OK, light: slot_light[s],
                                          turn_on: slot_is_on[s], last: 1'b0});
              end
            end
            awaited_words.push_back('{kind: 1'b0, status: ST_OK, light: '0,
                                      turn_on: 1'b0, last: 1'b1});
          end
        endcase
      end
      words_awaited <= awaited_words.size();
    end
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the timed event table: clock, reset, request stimulus, result sink and verdict.
`timescale 1ns / 1ps

module tb_top;
  import tet_pkg::*;

  localparam int SLOTS         = EVENT_SLOTS_DEF;
  localparam int RANDOM_WORDS  = 230;
  localparam int FILL_WORDS    = SLOTS + 3;
  localparam int HOT_EVENTS    = 6;
  localparam int QUIET_LIMIT   = 3000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic [39:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = MODE_TICK;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;

  bit feed_idle = 1'b1;
  bit sink_idle = 1'b1;
  int words_awaited;
  int mismatches;
  int quiet_cycles = 0;

  // Pool of recurring events so that removes and ticks actually hit stored slots.
  logic [LIGHT_IN_W-1:0] hot_light  [HOT_EVENTS];
  logic [DAY_W-1:0]      hot_day    [HOT_EVENTS];
  logic [MINUTE_W-1:0]   hot_minute [HOT_EVENTS];

  timed_event_table_top #(.EVENT_SLOTS(SLOTS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  tet_checker #(.SLOTS(SLOTS)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .words_awaited (words_awaited),
    .mismatches    (mismatches)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result sink: stalls at random while idling is enabled.
  always @(posedge clk) begin
    out_tready <= !sink_idle || ($urandom_range(99) >= 27);
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** timed_event_table_top: FAILED **");
        $finish;
      end
    end
  end

  // Present one request word and return at the edge where it is taken.
  task automatic send_word(mode_t mode, logic [LIGHT_IN_W-1:0] light, logic [DAY_W-1:0] day,
                           logic [MINUTE_W-1:0] minute, logic [TODAY_W-1:0] today,
                           logic [MINUTE_W-1:0] now);
    if (feed_idle) begin
      while ($urandom_range(99) < 27) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {5'b0, now, today, minute, day, light};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the request channel until every awaited result word has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (words_awaited != 0);
  endtask

  initial begin : stimulus
    int    pick;
    int    k;
    mode_t sched_mode;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes of every field, each day code and the edge cases.
    send_word(MODE_TICK,   6'd0,  4'd0,  11'd0,    3'd0, 11'd0);
    send_word(MODE_ON,     6'd0,  4'd0,  11'd0,    3'd7, 11'd2047);
    send_word(MODE_OFF,    6'd31, DAY_EVERY, 11'd1439, 3'd0, 11'd0);
    send_word(MODE_ON,     6'd32, 4'd1,  11'd5,    3'd2, 11'd5);
    send_word(MODE_OFF,    6'd63, 4'd15, 11'd2047, 3'd7, 11'd2047);
    send_word(MODE_ON,     6'd17, 4'd15, 11'd2047, 3'd1, 11'd1);
    send_word(MODE_ON,     6'd5,  DAY_WEEKDAY, 11'd1439, 3'd0, 11'd0);
    send_word(MODE_OFF,    6'd6,  DAY_WEEKEND, 11'd1439, 3'd0, 11'd0);
    send_word(MODE_ON,     6'd9,  4'd3,  11'd1439, 3'd0, 11'd0);
    send_word(MODE_TICK,   6'd0,  4'd0,  11'd0,    3'd0, 11'd0);
    send_word(MODE_TICK,   6'd0,  4'd0,  11'd0,    3'd6, 11'd1439);
    send_word(MODE_TICK,   6'd0,  4'd0,  11'd0,    3'd3, 11'd1439);
    send_word(MODE_TICK,   6'd0,  4'd0,  11'd0,    3'd7, 11'd1439);
    send_word(MODE_TICK,   6'd63, 4'd15, 11'd2047, 3'd5, 11'd2047);
    send_word(MODE_TICK,   6'd0,  4'd0,  11'd0,    3'd0, 11'd1439);
    send_word(MODE_REMOVE, 6'd63, 4'd0,  11'd0,    3'd0, 11'd0);
    send_word(MODE_ON,     6'd0,  4'd0,  11'd0,    3'd0, 11'd0);
    send_word(MODE_REMOVE, 6'd0,  4'd0,  11'd0,    3'd0, 11'd0);
    send_word(MODE_REMOVE, 6'd31, DAY_EVERY, 11'd1438, 3'd0, 11'd0);
    send_word(MODE_TICK,   6'd0,  4'd0,  11'd0,    3'd0, 11'd0);
    send_word(MODE_TICK,   6'd0,  4'd0,  11'd0,    3'd1, 11'd1439);

    // Random: mostly schedules, removes and ticks on a small pool of recurring events.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) begin
        for (int h = 0; h < HOT_EVENTS; h++) begin
          hot_light[h]  = LIGHT_IN_W'($urandom_range(31));
          hot_day[h]    = DAY_W'($urandom_range(9));
          hot_minute[h] = MINUTE_W'($urandom_range(1439));
        end
      end
      // A long stretch with no idling on either side.
      if (n == 60) begin
        feed_idle <= 1'b0;
        sink_idle <= 1'b0;
      end
      if (n == 120) begin
        feed_idle <= 1'b1;
        sink_idle <= 1'b1;
      end
      if (n == 140) begin
        wait_drained();
      end
      // Burst of schedules that overruns the table.
      if (n == 180) begin
        for (int f = 0; f < FILL_WORDS; f++) begin
          k = $urandom_range(HOT_EVENTS - 1);
          sched_mode = $urandom_range(1) ? MODE_ON : MODE_OFF;
          send_word(sched_mode, hot_light[k], hot_day[k], hot_minute[k],
                    TODAY_W'($urandom), MINUTE_W'($urandom));
        end
      end

      pick = $urandom_range(99);
      k    = $urandom_range(HOT_EVENTS - 1);
      if (pick < 45) begin
        sched_mode = $urandom_range(1) ? MODE_ON : MODE_OFF;
        if ($urandom_range(9) == 0) begin
          send_word(sched_mode, LIGHT_IN_W'($urandom), DAY_W'($urandom), MINUTE_W'($urandom),
                    TODAY_W'($urandom), MINUTE_W'($urandom));
        end else begin
          send_word(sched_mode, hot_light[k], hot_day[k], hot_minute[k],
                    TODAY_W'($urandom), MINUTE_W'($urandom));
        end
      end else if (pick < 65) begin
        if ($urandom_range(9) < 8) begin
          send_word(MODE_REMOVE, hot_light[k], hot_day[k], hot_minute[k],
                    TODAY_W'($urandom), MINUTE_W'($urandom));
        end else begin
          send_word(MODE_REMOVE, LIGHT_IN_W'($urandom), DAY_W'($urandom), MINUTE_W'($urandom),
                    TODAY_W'($urandom), MINUTE_W'($urandom));
        end
      end else begin
        if ($urandom_range(9) < 8) begin
          send_word(MODE_TICK, LIGHT_IN_W'($urandom), DAY_W'($urandom), MINUTE_W'($urandom),
                    TODAY_W'($urandom), hot_minute[k]);
        end else begin
          send_word(MODE_TICK, LIGHT_IN_W'($urandom), DAY_W'($urandom), MINUTE_W'($urandom),
                    TODAY_W'($urandom), MINUTE_W'($urandom));
        end
      end
    end

    // Let the last words drain, then allow for any late stray word.
    wait_drained();
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** timed_event_table_top: PASSED **");
    end else begin
      $display("** timed_event_table_top: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/tet_pkg.sv
rtl/tet_cell.sv
rtl/timed_event_table_top.sv
sim/tet_checker.sv
sim/tb_top.sv
